// ===== hw/rtl/hrsl_pkg.sv =====
// Package for the hash ring successor lookup block.
// Holds the command and status codes, the request and response payloads and FSM states.
package hrsl_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_COUNT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] key;
        logic [3:0]  node_id;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  owner_node;
        logic [31:0] hit_count;
    } t_rsp;

    typedef struct packed {
        t_req req;
        logic node_ok;
    } t_qent;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// ===== hw/rtl/hrsl_front.sv =====
// Front end: accepts requests, checks the node id range and queues them.
// Depends on hrsl_pkg.
module hrsl_front #(
    parameter int NODE_COUNT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrsl_pkg::t_req   i_req,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output hrsl_pkg::t_qent  o_head,
    output logic             o_head_valid,
    input  logic             i_pop
);

    hrsl_pkg::t_qent r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_req_ready  = (r_cnt != 2'd2);
    assign push         = i_req_valid && o_req_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].req     <= i_req;
            r_q[r_wp].node_ok <= (32'(i_req.node_id) < NODE_COUNT);
        end
    end

endmodule

// ===== hw/rtl/hrsl_back.sv =====
// Back end: sorted cell chain of ring points, node hit counters and the response register.
// Depends on hrsl_pkg.
module hrsl_back #(
    parameter int RING_ENTRIES = 256,
    parameter int NODE_COUNT   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrsl_pkg::t_qent  i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    output hrsl_pkg::t_rsp   o_rsp,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready
);

    localparam int CW  = $clog2(RING_ENTRIES + 1);
    localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    hrsl_pkg::t_state r_state, n_state;
    hrsl_pkg::t_qent  r_op;
    logic [31:0]      r_keys   [RING_ENTRIES];
    logic [3:0]       r_owners [RING_ENTRIES];
    logic [CW-1:0]    r_count;
    logic [31:0]      r_hits   [NODE_COUNT];
    logic [RING_ENTRIES-1:0] r_ge;
    logic             r_dup;
    logic [3:0]       r_owner;
    hrsl_pkg::t_rsp   r_out;
    logic             r_out_valid;

    logic [RING_ENTRIES-1:0] ge, gt, eq, sel;
    logic [3:0]       owner_sel;
    logic             commit;
    logic             ins_ok, rem_ok, owner_ok;
    logic [NIW-1:0]   hidx;
    logic [31:0]      hval, hnext;
    hrsl_pkg::t_rsp   rsp;

    always_comb begin
        owner_sel = 4'd0;
        for (int i = 0; i < RING_ENTRIES; i++) begin
            ge[i] = (CW'(i) >= r_count) || (r_keys[i] >= i_head.req.key);
            gt[i] = (CW'(i) >= r_count) || (r_keys[i] > i_head.req.key);
            eq[i] = (CW'(i) < r_count) && (r_keys[i] == i_head.req.key);
            sel[i] = gt[i] && (CW'(i) < r_count) && ((i == 0) || !gt[(i == 0) ? 0 : i - 1]);
            if (sel[i]) owner_sel = owner_sel | r_owners[i];
        end
        if (sel == '0) owner_sel = r_owners[0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hrsl_pkg::S_IDLE: if (o_pop) n_state = hrsl_pkg::S_EXEC;
            hrsl_pkg::S_EXEC: n_state = hrsl_pkg::S_IDLE;
            default:          n_state = hrsl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        commit = 1'b0;
        unique case (r_state)
            hrsl_pkg::S_IDLE: o_pop = i_head_valid && (!r_out_valid || i_rsp_ready);
            hrsl_pkg::S_EXEC: commit = 1'b1;
            default:          o_pop = 1'b0;
        endcase
    end

    assign ins_ok   = !r_dup && r_op.node_ok && (32'(r_count) < RING_ENTRIES);
    assign rem_ok   = r_dup;
    assign owner_ok = 32'(r_owner) < NODE_COUNT;
    assign hidx     = (r_op.req.command == hrsl_pkg::CMD_LOOKUP) ?
                      NIW'(r_owner) : NIW'(r_op.req.node_id);
    assign hval     = r_hits[hidx];
    assign hnext    = (hval == 32'hFFFF_FFFF) ? hval : hval + 32'd1;

    always_comb begin
        rsp = '{status: hrsl_pkg::ST_OK, owner_node: 4'd0, hit_count: 32'd0};
        case (r_op.req.command)
            hrsl_pkg::CMD_INSERT: begin
                if (r_dup || !r_op.node_ok) rsp.status = hrsl_pkg::ST_MISS;
                else if (!ins_ok)          rsp.status = hrsl_pkg::ST_FULL;
            end
            hrsl_pkg::CMD_REMOVE: if (!rem_ok) rsp.status = hrsl_pkg::ST_MISS;
            hrsl_pkg::CMD_LOOKUP: begin
                if (r_count == '0) begin
                    rsp.status = hrsl_pkg::ST_EMPTY;
                end else begin
                    rsp.owner_node = r_owner;
                    if (owner_ok) rsp.hit_count = hnext;
                end
            end
            default: begin
                if (r_op.node_ok) rsp.hit_count = hval;
                else              rsp.status = hrsl_pkg::ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= i_head;
            r_ge    <= ge;
            r_dup   <= |eq;
            r_owner <= owner_sel;
        end
        if (commit) r_out <= rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrsl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            for (int n = 0; n < NODE_COUNT; n++) r_hits[n] <= 32'd0;
        end else begin
            r_state <= n_state;
            if (commit)                r_out_valid <= 1'b1;
            else if (i_rsp_ready)      r_out_valid <= 1'b0;
            if (commit) begin
                if (r_op.req.command == hrsl_pkg::CMD_INSERT && ins_ok) r_count <= r_count + 1'b1;
                if (r_op.req.command == hrsl_pkg::CMD_REMOVE && rem_ok) r_count <= r_count - 1'b1;
                if (r_op.req.command == hrsl_pkg::CMD_LOOKUP && r_count != '0 && owner_ok)
                    r_hits[hidx] <= hnext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_ENTRIES; i++) begin
                r_keys[i]   <= 32'd0;
                r_owners[i] <= 4'd0;
            end
        end else if (commit) begin
            for (int i = 0; i < RING_ENTRIES; i++) begin
                if (r_op.req.command == hrsl_pkg::CMD_INSERT && ins_ok && r_ge[i]) begin
                    if (i > 0 && r_ge[(i == 0) ? 0 : i - 1]) begin
                        r_keys[i]   <= r_keys[(i == 0) ? 0 : i - 1];
                        r_owners[i] <= r_owners[(i == 0) ? 0 : i - 1];
                    end else begin
                        r_keys[i]   <= r_op.req.key;
                        r_owners[i] <= r_op.req.node_id;
                    end
                end else if (r_op.req.command == hrsl_pkg::CMD_REMOVE && rem_ok && r_ge[i]
                             && i < RING_ENTRIES - 1) begin
                    r_keys[i]   <= r_keys[(i < RING_ENTRIES - 1) ? i + 1 : i];
                    r_owners[i] <= r_owners[(i < RING_ENTRIES - 1) ? i + 1 : i];
                end
            end
        end
    end

    assign o_rsp       = r_out;
    assign o_rsp_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= RING_ENTRIES)
        else $error("Point count exceeds the table size.");
    a_exec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hrsl_pkg::S_EXEC |=> r_state == hrsl_pkg::S_IDLE)
        else $error("Execute state lasted more than one cycle.");
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == hrsl_pkg::S_EXEC))
        else $error("Response appeared without an executed request.");
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> !r_out_valid)
        else $error("Request taken while the response register was still full.");
`endif

endmodule

// ===== hw/rtl/hash_ring_successor_lookup.sv =====
// Consistent-hashing ring with successor lookup over a sorted chain of point cells.
// A request goes from the front queue through compare and commit passes to the response register.
// The back end pops the next request only after the last commit and when the response slot is free.
// Reset (synchronous, active low) clears all points, the point count and every hit counter.
// Depends on hrsl_pkg, hrsl_front and hrsl_back.
module hash_ring_successor_lookup #(
    parameter int RING_ENTRIES = 256,
    parameter int NODE_COUNT   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrsl_pkg::t_req  i_req,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output hrsl_pkg::t_rsp  o_rsp,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready
);

    hrsl_pkg::t_qent head;
    logic            head_valid, pop;

    hrsl_front #(.NODE_COUNT(NODE_COUNT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    hrsl_back #(.RING_ENTRIES(RING_ENTRIES), .NODE_COUNT(NODE_COUNT)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_rsp        (o_rsp),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready)
    );

endmodule

// ===== tb/hash_ring_successor_lookup_checker.sv =====
// Checker for the hash ring successor lookup block: watches both channels,
// predicts each response from a behavioral copy of the ring, and compares.
// Depends on hrsl_pkg.
module hash_ring_successor_lookup_checker #(
    parameter int RING_ENTRIES = 256,
    parameter int NODE_COUNT   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hrsl_pkg::t_req i_req,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  hrsl_pkg::t_rsp i_rsp,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    output int             o_errors,
    output int             o_pending,
    output int             o_lookups,
    output int             o_full_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import hrsl_pkg::*;

    logic [31:0] ring_keys[$];
    logic [3:0]  ring_owners[$];
    logic [31:0] node_hits[NODE_COUNT];
    t_rsp        expected_rsps[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic int first_at_or_above(input logic [31:0] k, input bit strict);
        int i;
        for (i = 0; i < ring_keys.size(); i++) begin
            if (strict ? (ring_keys[i] > k) : (ring_keys[i] >= k)) return i;
        end
        return ring_keys.size();
    endfunction

    function automatic t_rsp predict_ring(input t_req r);
        t_rsp p;
        int   pos;
        p = '{status: ST_OK, owner_node: 4'd0, hit_count: 32'd0};
        case (r.command)
            CMD_INSERT: begin
                pos = first_at_or_above(r.key, 1'b0);
                if (pos < ring_keys.size() && ring_keys[pos] == r.key) p.status = ST_MISS;
                else if (int'(r.node_id) >= NODE_COUNT) p.status = ST_MISS;
                else if (ring_keys.size() >= RING_ENTRIES) begin
                    p.status = ST_FULL;
                    o_full_hits++;
                end else begin
                    ring_keys.insert(pos, r.key);
                    ring_owners.insert(pos, r.node_id);
                end
            end
            CMD_REMOVE: begin
                pos = first_at_or_above(r.key, 1'b0);
                if (pos < ring_keys.size() && ring_keys[pos] == r.key) begin
                    ring_keys.delete(pos);
                    ring_owners.delete(pos);
                end else p.status = ST_MISS;
            end
            CMD_LOOKUP: begin
                o_lookups++;
                if (ring_keys.size() == 0) p.status = ST_EMPTY;
                else begin
                    pos = first_at_or_above(r.key, 1'b1);
                    if (pos >= ring_keys.size()) pos = 0;
                    p.owner_node = ring_owners[pos];
                    if (node_hits[p.owner_node] != 32'hFFFF_FFFF)
                        node_hits[p.owner_node]++;
                    p.hit_count = node_hits[p.owner_node];
                end
            end
            default: begin
                if (int'(r.node_id) < NODE_COUNT) p.hit_count = node_hits[r.node_id];
                else p.status = ST_MISS;
            end
        endcase
        return p;
    endfunction

    initial begin
        o_errors = 0;
        o_lookups = 0;
        o_full_hits = 0;
        foreach (node_hits[i]) node_hits[i] = '0;
    end

    assign o_pending = expected_rsps.size();

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && i_req_valid && i_req_ready) expected_rsps.push_back(predict_ring(i_req));
        if (i_rst_n && i_rsp_valid && i_rsp_ready) begin
            if (expected_rsps.size() == 0) report("unexpected response", 32'd0, 32'd0);
            else begin
                want = expected_rsps.pop_front();
                if (i_rsp.status !== want.status)
                    report("status", 32'(i_rsp.status), 32'(want.status));
                if (i_rsp.owner_node !== want.owner_node)
                    report("owner_node", 32'(i_rsp.owner_node), 32'(want.owner_node));
                if (i_rsp.hit_count !== want.hit_count)
                    report("hit_count", i_rsp.hit_count, want.hit_count);
            end
        end
    end
endmodule

// ===== tb/hash_ring_successor_lookup_tb.sv =====
// Testbench top for the hash ring successor lookup block: drives requests with
// bursty gaps and response stalls, and gives the verdict from the checker.
// Depends on hrsl_pkg, the block and hash_ring_successor_lookup_checker.
module hash_ring_successor_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hrsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    t_req i_req = '0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_rsp o_rsp;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    int   mismatches, pending, lookups, full_hits;
    int   idle_cycles = 0;
    bit   hold_rsp = 1'b0;
    bit   stim_done = 1'b0;
    logic [31:0] used_keys[$];

    always #1 i_clk = ~i_clk;

    hash_ring_successor_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready), .o_rsp(o_rsp), .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready)
    );

    hash_ring_successor_lookup_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_req_valid(i_req_valid),
        .i_req_ready(o_req_ready), .i_rsp(o_rsp), .i_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready), .o_errors(mismatches), .o_pending(pending),
        .o_lookups(lookups), .o_full_hits(full_hits)
    );

    task automatic send_request(input t_cmd c, input logic [31:0] k, input logic [3:0] n);
        i_req <= '{command: c, key: k, node_id: n};
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        used_keys.push_back(k);
        if (used_keys.size() > 300) void'(used_keys.pop_front());
    endtask

    task automatic pause_sender();
        i_req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: if (used_keys.size() > 0)
                return used_keys[$urandom_range(0, used_keys.size() - 1)];
            default: ;
        endcase
        return $urandom();
    endfunction

    function automatic t_cmd pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return CMD_INSERT;
        if (r < 55) return CMD_REMOVE;
        if (r < 85) return CMD_LOOKUP;
        return CMD_COUNT;
    endfunction

    always @(posedge i_clk) begin
        if (hold_rsp) i_rsp_ready <= 1'b0;
        else if (($urandom_range(0, 15) < 4) && ($urandom_range(0, 3) != 0)) i_rsp_ready <= 1'b0;
        else i_rsp_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (40) @(posedge i_clk);
        hold_rsp = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_rsp = 1'b0;
    end

    initial begin
        int i;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_request(CMD_LOOKUP, 32'h0, 4'd0);
        send_request(CMD_REMOVE, 32'h5, 4'd0);
        send_request(CMD_COUNT, 32'h0, 4'd15);
        send_request(CMD_INSERT, 32'h0, 4'd15);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_request(CMD_INSERT, 32'h8000_0000, 4'd5);
        send_request(CMD_INSERT, 32'h8000_0000, 4'd6);
        send_request(CMD_LOOKUP, 32'h0, 4'd0);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 4'd0);
        send_request(CMD_LOOKUP, 32'h7FFF_FFFF, 4'd0);
        send_request(CMD_LOOKUP, 32'h8000_0000, 4'd0);
        send_request(CMD_COUNT, 32'hFFFF_FFFF, 4'd15);
        send_request(CMD_COUNT, 32'h0, 4'd5);
        send_request(CMD_REMOVE, 32'h8000_0000, 4'd0);
        send_request(CMD_REMOVE, 32'h8000_0000, 4'd0);
        send_request(CMD_REMOVE, 32'h0, 4'd0);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 4'd0);
        send_request(CMD_LOOKUP, 32'h1234, 4'd0);
        // Fill the table past capacity, then read it and drain it partly.
        for (i = 0; i < 260; i++) begin
            send_request(CMD_INSERT, $urandom(), 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 7) == 0) pause_sender();
        end
        for (i = 0; i < 1500; i++) begin
            if ($urandom_range(0, 9) == 0) pause_sender();
            send_request(pick_cmd(), pick_key(), 4'($urandom_range(0, 15)));
        end
        i_req_valid <= 1'b0;
        stim_done = 1'b1;
        i = 0;
        while (pending != 0 && i < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            i++;
        end
        repeat (10) @(posedge i_clk);
        $display("Ran about 1780 requests with %0d lookups and %0d full-table inserts.",
                 lookups, full_hits);
        if (mismatches == 0 && pending == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/hrsl_pkg.sv
hw/rtl/hrsl_front.sv
hw/rtl/hrsl_back.sv
hw/rtl/hash_ring_successor_lookup.sv
tb/hash_ring_successor_lookup_checker.sv
tb/hash_ring_successor_lookup_tb.sv
